@@ rtl/fba_pkg.sv @@
// Shared constants, types and helper functions of the frame bitmap allocator.
// Depends on nothing; every other file of the block but fba_ram uses it.
package fba_pkg;

    localparam int NUM_FRAMES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int FRAME_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int GROUP_BITS  = 16;
    localparam int GROUP_COUNT = WORD_COUNT / GROUP_BITS;
    localparam int GROUP_AW    = $clog2(GROUP_COUNT);
    localparam int GROUP_SEL_W = $clog2(GROUP_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] FRAME_LIMIT       = COUNT_W'(NUM_FRAMES);
    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4096);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_DONE = 2'd0;
    localparam status_t STATUS_NOOP = 2'd1;
    localparam status_t STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_REPLY,
        OP_ALLOC,
        OP_FREE,
        OP_TEST
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [FRAME_W-1:0] frame;
        status_t            status;
        logic               user;
        logic               rw;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        status_t            status;
        logic               present;
        logic               read_write;
        logic               user_access;
        logic               frame_in_use;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WORD,
        ST_DONE
    } back_state_t;

    function automatic logic [BIT_AW-1:0] lowest_zero_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [GROUP_SEL_W-1:0] lowest_zero_group(
        input logic [GROUP_BITS-1:0] g);
        logic [GROUP_SEL_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_BITS - 1; i >= 0; i--)
        begin
            if (!g[i])
            begin
                idx = GROUP_SEL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/fba_if.sv @@
// Request and response channel interfaces of the frame bitmap allocator.
// Depends on fba_pkg for field widths.
interface fba_req_if;
    logic                           valid;
    logic                           ready;
    logic [fba_pkg::KIND_W-1:0]     kind;
    logic [fba_pkg::FRAME_W-1:0]    page_frame;
    logic                           kernel_flag;
    logic                           writable;

    modport source (output valid, kind, page_frame, kernel_flag, writable, input ready);
    modport sink   (input valid, kind, page_frame, kernel_flag, writable, output ready);
endinterface

interface fba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fba_pkg::FRAME_W-1:0]    frame_index;
    logic [fba_pkg::STATUS_W-1:0]   status;
    logic                           present;
    logic                           read_write;
    logic                           user_access;
    logic                           frame_in_use;

    modport source (output valid, frame_index, status, present, read_write, user_access,
                    frame_in_use, input ready);
    modport sink   (input valid, frame_index, status, present, read_write, user_access,
                    frame_in_use, output ready);
endinterface

@@ rtl/fba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

@@ rtl/fba_front.sv @@
// Front end: accepts request beats and classifies them into back-end commands.
// Depends on fba_pkg and fba_req_if.
module fba_front (
    fba_req_if.sink          req,
    input  fba_pkg::q_stat_t q_stat,
    output logic             q_push,
    output fba_pkg::cmd_t    q_cmd
);
    import fba_pkg::*;

    assign req.ready = !q_stat.full;
    assign q_push    = req.valid && !q_stat.full;

    // Resolve trivial cases here; the back end only sees a canned reply for them.
    always_comb
    begin
        q_cmd        = '0;
        q_cmd.op     = OP_REPLY;
        q_cmd.status = STATUS_NOOP;
        q_cmd.user   = req.kernel_flag;
        q_cmd.rw     = req.writable;
        case (req.kind)
            KIND_ALLOC:
            begin
                if (req.page_frame != '0)
                begin
                    q_cmd.frame = req.page_frame;
                end
                else
                begin
                    q_cmd.op     = OP_ALLOC;
                    q_cmd.status = STATUS_DONE;
                end
            end
            KIND_FREE:
            begin
                if (req.page_frame != '0)
                begin
                    q_cmd.op     = OP_FREE;
                    q_cmd.frame  = req.page_frame;
                    q_cmd.status = STATUS_DONE;
                end
            end
            KIND_TEST:
            begin
                q_cmd.op     = OP_TEST;
                q_cmd.frame  = req.page_frame;
                q_cmd.status = STATUS_DONE;
            end
            default:
            begin
                q_cmd.op = OP_REPLY;
            end
        endcase
    end

endmodule

@@ rtl/fba_queue.sv @@
// Short command queue between front end and back end.
// Depends on fba_pkg.
module fba_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fba_pkg::cmd_t    push_data,
    input  logic             pop,
    output logic             q_valid,
    output fba_pkg::cmd_t    q_data,
    output fba_pkg::q_stat_t q_stat
);
    import fba_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_valid      = !q_stat.empty;
    assign q_data       = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/fba_back.sv @@
// Back end: executes commands against the used-frame bitmap and holds the response.
// Depends on fba_pkg and fba_ram.
module fba_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fba_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                           q_valid,
    input  fba_pkg::cmd_t                  q_cmd,
    output logic                           q_pop,
    output logic                           rsp_valid,
    output fba_pkg::res_t                  rsp_data,
    input  logic                           rsp_ready
);
    import fba_pkg::*;

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    res_t                 res_reg, res_next;
    logic [WORD_AW-1:0]   addr_reg, addr_next;
    logic [GROUP_AW-1:0]  grp_reg, grp_next;
    logic [COUNT_W-1:0]   frame_count_reg;
    logic [WORD_COUNT-1:0] full_reg;
    logic [WORD_COUNT-1:0] row_valid_reg;
    logic                 out_valid_reg;
    res_t                 out_data_reg;

    logic                 ram_wr_en;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WORD_AW-1:0]   ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    logic [GROUP_BITS-1:0]  group_bits;
    logic                   group_has_free;
    logic [GROUP_SEL_W-1:0] group_zero;
    logic [WORD_BITS-1:0]   word_data;
    logic [BIT_AW-1:0]      bit_sel;
    logic [BIT_AW-1:0]      free_bit;
    logic [FRAME_W-1:0]     cand_frame;
    logic [COUNT_W-1:0]     limit;
    logic                   out_load;

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign group_bits     = full_reg[grp_reg * GROUP_BITS +: GROUP_BITS];
    assign group_has_free = !(&group_bits);
    assign group_zero     = lowest_zero_group(group_bits);
    // A row never written reads as all free.
    assign word_data      = row_valid_reg[addr_reg] ? ram_rd_data : '0;
    assign bit_sel        = cmd_reg.frame[BIT_AW-1:0];
    assign free_bit       = lowest_zero_bit(word_data);
    assign cand_frame     = {addr_reg, free_bit};
    assign limit          = (frame_count_reg > FRAME_LIMIT) ? FRAME_LIMIT : frame_count_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        res_next    = res_reg;
        addr_next   = addr_reg;
        grp_next    = grp_reg;
        q_pop       = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = q_cmd.frame[FRAME_W-1:BIT_AW];
        ram_wr_en   = 1'b0;
        ram_wr_data = word_data;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    res_next = '0;
                    case (q_cmd.op)
                        OP_REPLY:
                        begin
                            res_next.frame_index = q_cmd.frame;
                            res_next.status      = q_cmd.status;
                            state_next           = ST_DONE;
                        end
                        OP_ALLOC:
                        begin
                            grp_next   = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            ram_rd_en  = 1'b1;
                            addr_next  = q_cmd.frame[FRAME_W-1:BIT_AW];
                            state_next = ST_WORD;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (group_has_free)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = {grp_reg, group_zero};
                    addr_next   = {grp_reg, group_zero};
                    state_next  = ST_WORD;
                end
                else if (grp_reg == GROUP_AW'(GROUP_COUNT - 1))
                begin
                    res_next.status = STATUS_FULL;
                    state_next      = ST_DONE;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            ST_WORD:
            begin
                state_next = ST_DONE;
                case (cmd_reg.op)
                    OP_TEST:
                    begin
                        res_next.frame_index  = cmd_reg.frame;
                        res_next.frame_in_use = word_data[bit_sel];
                    end
                    OP_FREE:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = word_data & ~(WORD_BITS'(1) << bit_sel);
                    end
                    OP_ALLOC:
                    begin
                        if ({1'b0, cand_frame} < limit)
                        begin
                            ram_wr_en            = 1'b1;
                            ram_wr_data          = word_data | (WORD_BITS'(1) << free_bit);
                            res_next.frame_index = cand_frame;
                            res_next.present     = 1'b1;
                            res_next.read_write  = cmd_reg.rw;
                            res_next.user_access = cmd_reg.user;
                        end
                        else
                        begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    default:
                    begin
                        res_next.status = STATUS_NOOP;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FRAME_COUNT_RESET;
            full_reg        <= '0;
            row_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                frame_count_reg <= cfg_wr_data;
            end
            if (ram_wr_en)
            begin
                full_reg[addr_reg]      <= &ram_wr_data;
                row_valid_reg[addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        addr_reg <= addr_next;
        grp_reg  <= grp_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule

@@ rtl/frame_bitmap_allocator.sv @@
// Top level of the frame bitmap allocator: front end, command queue, back end.
// Depends on fba_pkg, fba_if, fba_front, fba_queue, fba_back (and fba_ram below it).
//
//  channel  dir  handshake        beat contents
//  -------  ---  ---------------  --------------------------------------------------
//  req      in   valid / ready    kind, page_frame, kernel_flag, writable
//  rsp      out  valid / ready    frame_index, status, present, read_write,
//                                 user_access, frame_in_use
//  cfg      in   cfg_wr_en        cfg_wr_data = frame_count (scan limit)
//
// Flow: one item at a time in the back end. Replies settled by the front end
// (already mapped, nothing to free, unused kind) go straight to the response; free and
// test read the bitmap word, then write or inspect it; allocate scans the full-word
// summary 16 words per cycle over 8 groups, then reads one word and writes it back
// if the frame is under the scan limit; with no free word at all it skips the read.
// Reset: the bitmap RAM gets no clearing pass; per-word valid flags cleared by
// rst_n make untouched words read as all free, so the block is ready at once.
// Stalls: the two-entry queue keeps taking request beats while the back end works,
// and the response register holds a finished beat while the next item is fetched.
module frame_bitmap_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [fba_pkg::COUNT_W-1:0] cfg_wr_data,
    fba_req_if.sink                     req,
    fba_rsp_if.source                   rsp
);
    import fba_pkg::*;

    logic    q_push;
    cmd_t    q_push_cmd;
    logic    q_valid;
    cmd_t    q_head;
    q_stat_t q_stat;
    logic    q_pop;
    logic    rsp_valid;
    res_t    rsp_data;

    // Classify each request beat and hand it to the queue.
    fba_front u_front (
        .req    (req),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // Decouple acceptance from execution.
    fba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_cmd),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_stat    (q_stat)
    );

    // Execute against the bitmap and hold the response beat.
    fba_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (q_head),
        .q_pop       (q_pop),
        .rsp_valid   (rsp_valid),
        .rsp_data    (rsp_data),
        .rsp_ready   (rsp.ready)
    );

    assign rsp.valid        = rsp_valid;
    assign rsp.frame_index  = rsp_data.frame_index;
    assign rsp.status       = rsp_data.status;
    assign rsp.present      = rsp_data.present;
    assign rsp.read_write   = rsp_data.read_write;
    assign rsp.user_access  = rsp_data.user_access;
    assign rsp.frame_in_use = rsp_data.frame_in_use;

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // A queue that reports full cannot also be empty, and the back end pops only
    // what is there.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty) && (!q_pop || q_valid))
        else $error("queue status inconsistent");

    // A granted page is a clean success, never mixed with a test answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.present) |-> (rsp.status == STATUS_DONE && !rsp.frame_in_use))
        else $error("allocation response with bad status");

    // A failed allocation returns frame zero and no page bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_FULL) |->
        (rsp.frame_index == '0 && !rsp.present && !rsp.read_write && !rsp.user_access))
        else $error("no-free response carries data");

endmodule
